@@ rtl/core/abkf_pkg.sv @@
// Package for the angle/bias Kalman filter: fixed-point constants, command
// and status structs, controller state enum, and shared helpers.
// No dependencies.
package abkf_pkg;

    localparam logic [31:0] QANGLE_RST  = 32'd16777;
    localparam logic [31:0] QBIAS_RST   = 32'd50332;
    localparam logic [31:0] RMEAS_RST   = 32'd503316;
    localparam int          FRAC_P      = 24;
    localparam int          DIV_BITS    = 57;

    localparam logic [1:0] REG_Q_ANGLE = 2'd0;
    localparam logic [1:0] REG_Q_BIAS  = 2'd1;
    localparam logic [1:0] REG_R_MEAS  = 2'd2;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SETANG,
        OP_URATE,
        OP_MUL_ANG,
        OP_ANG,
        OP_MUL_DTP11,
        OP_DTP11,
        OP_MUL_P00,
        OP_P00,
        OP_MUL_P11,
        OP_P11,
        OP_S,
        OP_DIV_START,
        OP_K0,
        OP_K1,
        OP_Y,
        OP_MUL_KA,
        OP_UPD_ANG,
        OP_MUL_KB,
        OP_UPD_BIAS,
        OP_MUL_C0,
        OP_UPD_P00,
        OP_MUL_C1,
        OP_UPD_P01,
        OP_MUL_C2,
        OP_UPD_P10,
        OP_MUL_C3,
        OP_UPD_P11,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op  op;
        logic div_sel;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic s_zero;
        logic out_full;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)       sat32 = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
        else                           sat32 = v[31:0];
    endfunction

    // Round to nearest, ties up, of v / 2^24 (arithmetic shift floors)
    function automatic logic signed [63:0] rnd24(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + 64'sd8388608;
        rnd24 = t >>> FRAC_P;
    endfunction

endpackage

@@ rtl/core/abkf_div.sv @@
// Restoring signed divider, one quotient bit a cycle, truncates toward zero.
// Depends on abkf_pkg.
module abkf_div
    import abkf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [56:0]  i_num,
    input  logic signed [34:0]  i_den,
    output logic                o_busy,
    output logic signed [56:0]  o_quot
);
    logic [5:0]  r_cnt;
    logic [56:0] r_q;
    logic [35:0] r_rem;
    logic [34:0] r_den;
    logic        r_neg;
    logic        r_busy;
    logic [35:0] w_try;

    assign w_try = {r_rem[34:0], r_q[56]} - {1'b0, r_den};

    // Iterate magnitude division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(DIV_BITS);
            r_q    <= i_num[56] ? 57'(-i_num) : i_num;
            r_den  <= i_den[34] ? 35'(-i_den) : i_den;
            r_neg  <= i_num[56] ^ i_den[34];
            r_rem  <= '0;
        end else if (r_busy) begin
            if (!w_try[35]) begin
                r_rem <= w_try;
                r_q   <= {r_q[55:0], 1'b1};
            end else begin
                r_rem <= {r_rem[34:0], r_q[56]};
                r_q   <= {r_q[55:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_neg ? 57'(-r_q) : r_q;

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != 6'd0) else $error("divider count empty while busy");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("divider did not start");
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == 6'd1) |=> !r_busy) else $error("divider overran");
endmodule

@@ rtl/core/abkf_dp.sv @@
// Datapath: state, config registers, shared 33x33 multiplier, divider, output
// register. Depends on abkf_pkg and abkf_div.
module abkf_dp
    import abkf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [31:0] i_measured_angle,
    input  logic signed [31:0] i_measured_rate,
    input  logic [23:0]        i_step_time,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [31:0] o_angle_out,
    output logic signed [31:0] o_rate_out
);
    logic [31:0]        r_q_angle, r_q_bias, r_r_meas;
    logic signed [31:0] r_angle, r_bias, r_urate;
    logic signed [31:0] r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0] r_ma, r_mr, r_y, r_k0, r_k1, r_dtp11, r_p00t, r_p01t;
    logic [23:0]        r_dt;
    logic signed [34:0] r_s;
    logic signed [66:0] r_prod;
    logic signed [32:0] w_ma, w_mb;
    logic               r_out_valid;
    logic signed [31:0] r_ang_o, r_rate_o;
    logic               w_div_start;
    logic               w_div_busy;
    logic signed [56:0] w_num, w_quot;
    logic signed [34:0] w_sum;
    logic signed [63:0] w_rnd;

    // Divider shares gain numerators P00, P10, sign-extended and scaled by 2^24
    assign w_div_start = (i_cmd.op == OP_DIV_START) || (i_cmd.op == OP_K0);
    assign w_num = (i_cmd.op == OP_K0) ? {r_p10[31], r_p10, 24'd0}
                                       : {r_p00[31], r_p00, 24'd0};

    abkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_s),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    assign o_stat = '{div_busy: w_div_busy, s_zero: (r_s == '0), out_full: r_out_valid};

    // Multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        w_sum = '0;
        case (i_cmd.op)
            OP_MUL_ANG:   begin w_ma = {9'd0, r_dt}; w_mb = 33'(r_urate); end
            OP_MUL_DTP11: begin w_ma = {9'd0, r_dt}; w_mb = 33'(r_p11); end
            OP_MUL_P00: begin
                w_sum = 35'(r_dtp11) - 35'(r_p01) - 35'(r_p10) + 35'({1'b0, r_q_angle});
                w_ma = {9'd0, r_dt};
                w_mb = 33'(w_sum);
            end
            OP_MUL_P11: begin w_ma = {9'd0, r_dt}; w_mb = {1'b0, r_q_bias}; end
            OP_MUL_KA:  begin w_ma = 33'(r_k0); w_mb = 33'(r_y); end
            OP_MUL_KB:  begin w_ma = 33'(r_k1); w_mb = 33'(r_y); end
            OP_MUL_C0:  begin w_ma = 33'(r_k0); w_mb = 33'(r_p00t); end
            OP_MUL_C1:  begin w_ma = 33'(r_k0); w_mb = 33'(r_p01t); end
            OP_MUL_C2:  begin w_ma = 33'(r_k1); w_mb = 33'(r_p00t); end
            OP_MUL_C3:  begin w_ma = 33'(r_k1); w_mb = 33'(r_p01t); end
            default: ;
        endcase
    end

    // P00 sum can reach 35 bits; the 33-bit operand path does not cover it,
    // so handle that op with a wider product below.
    assign w_rnd = rnd24(64'(r_prod));

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_angle <= QANGLE_RST;
            r_q_bias  <= QBIAS_RST;
            r_r_meas  <= RMEAS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_Q_ANGLE: r_q_angle <= i_cfg_data;
                REG_Q_BIAS:  r_q_bias  <= i_cfg_data;
                REG_R_MEAS:  r_r_meas  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // State sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0; r_bias <= '0; r_urate <= '0;
            r_p00 <= '0; r_p01 <= '0; r_p10 <= '0; r_p11 <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (i_cmd.op)
                OP_LOAD: begin
                    r_ma <= i_measured_angle;
                    r_mr <= i_measured_rate;
                    r_dt <= i_step_time;
                end
                OP_SETANG: r_angle <= i_measured_angle;
                OP_URATE:  r_urate <= sat32(64'(r_mr) - 64'(r_bias));
                OP_MUL_ANG, OP_MUL_DTP11, OP_MUL_P11, OP_MUL_KA, OP_MUL_KB,
                OP_MUL_C0, OP_MUL_C1, OP_MUL_C2, OP_MUL_C3:
                    r_prod <= 67'(w_ma * w_mb);
                OP_MUL_P00: r_prod <= 67'($signed({9'd0, r_dt}) * w_sum);
                OP_ANG:   r_angle <= sat32(64'(r_angle) + w_rnd);
                OP_DTP11: r_dtp11 <= w_rnd[31:0];
                OP_P00: begin
                    r_p00 <= sat32(64'(r_p00) + w_rnd);
                    r_p01 <= sat32(64'(r_p01) - 64'(r_dtp11));
                    r_p10 <= sat32(64'(r_p10) - 64'(r_dtp11));
                end
                OP_P11: r_p11 <= sat32(64'(r_p11) + w_rnd);
                OP_S:   r_s   <= 35'(r_p00) + 35'({1'b0, r_r_meas});
                OP_K0: begin
                    r_k0 <= sat32(64'(w_quot));
                    r_k1 <= '0;
                end
                OP_K1: begin
                    if (i_cmd.div_sel) r_k1 <= sat32(64'(w_quot));
                    else begin r_k0 <= '0; r_k1 <= '0; end
                end
                OP_Y: begin
                    r_y <= sat32(64'(r_ma) - 64'(r_angle));
                    r_p00t <= r_p00;
                    r_p01t <= r_p01;
                end
                OP_UPD_ANG:  r_angle <= sat32(64'(r_angle) + w_rnd);
                OP_UPD_BIAS: r_bias  <= sat32(64'(r_bias) + w_rnd);
                OP_UPD_P00:  r_p00   <= sat32(64'(r_p00) - w_rnd);
                OP_UPD_P01:  r_p01   <= sat32(64'(r_p01) - w_rnd);
                OP_UPD_P10:  r_p10   <= sat32(64'(r_p10) - w_rnd);
                OP_UPD_P11:  r_p11   <= sat32(64'(r_p11) - w_rnd);
                OP_OUT: begin
                    r_out_valid <= 1'b1;
                    r_ang_o  <= r_angle;
                    r_rate_o <= r_urate;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_angle_out = r_ang_o;
    assign o_rate_out  = r_rate_o;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid && $stable(r_ang_o))
        else $error("result dropped while stalled");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_OUT) |-> !r_out_valid) else $error("result overwritten");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy) else $error("divider restarted busy");
endmodule

@@ rtl/core/abkf_ctrl.sv @@
// Controller: steps the datapath through predict, gain, correct and output ops, or set-angle.
// Depends on abkf_pkg.
module abkf_ctrl
    import abkf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_kind,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_div2, n_div2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_NONE;
            r_div2  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_div2  <= n_div2;
        end
    end

    // Next state and command
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_div2      = r_div2;
        o_in_ready  = 1'b0;
        o_cmd.op    = OP_NONE;
        o_cmd.div_sel = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = i_kind ? OP_SETANG : OP_LOAD;
                    n_op     = i_kind ? OP_OUT : OP_URATE;
                    n_state  = i_kind ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.op = r_op;
                case (r_op)
                    OP_S: n_op = OP_DIV_START;
                    OP_DIV_START: begin
                        if (i_stat.s_zero) begin
                            o_cmd.op = OP_K1;
                            n_op = OP_Y;
                        end else begin
                            n_state = ST_DIV_WAIT;
                            n_div2  = 1'b0;
                        end
                    end
                    OP_UPD_P11: begin
                        n_op = OP_OUT;
                        n_state = ST_DONE;
                    end
                    default: n_op = t_op'(r_op + 5'd1);
                endcase
            end
            ST_DIV_WAIT: begin
                if (!i_stat.div_busy) begin
                    if (!r_div2) begin
                        o_cmd.op = OP_K0;
                        n_div2 = 1'b1;
                    end else begin
                        o_cmd.op = OP_K1;
                        o_cmd.div_sel = 1'b1;
                        n_op = OP_Y;
                        n_state = ST_RUN;
                    end
                end
            end
            // Hold the result until the output register is free
            ST_DONE: begin
                if (!i_stat.out_full) begin
                    o_cmd.op = OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_stat.out_full) |=> r_state == ST_IDLE)
        else $error("done not left");
    a_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_WAIT && i_stat.div_busy) |=> r_state == ST_DIV_WAIT)
        else $error("left divider wait early");
endmodule

@@ rtl/core/angle_bias_kalman_filter.sv @@
// Angle/gyro-bias Kalman filter, controller plus shared-multiplier datapath.
// Update request: the result waits on two 57-step serial divisions, which are
// skipped when the innovation variance is zero; set-angle loads the angle.
// One request at a time; a new request is taken while the last result waits
// in the output register, and its result is held until that register frees.
// Synchronous active-low reset restores register defaults and zeroes state.
module angle_bias_kalman_filter
    import abkf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic signed [31:0] i_measured_angle,
    input  logic signed [31:0] i_measured_rate,
    input  logic [23:0]        i_step_time,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_angle_out,
    output logic signed [31:0] o_rate_out
);
    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    abkf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    abkf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_measured_angle (i_measured_angle),
        .i_measured_rate  (i_measured_rate),
        .i_step_time      (i_step_time),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_angle_out      (o_angle_out),
        .o_rate_out       (o_rate_out)
    );
endmodule
